### hw/rtl/mlr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer package
// Shared constants and the command control word passed from front to back.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned ColourBits   = 4;
  localparam int unsigned QueueDepth   = 4;

  // Input word kinds carried on tuser.
  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  typedef struct packed {
    logic is_start;
    logic dir_x_neg;
    logic dir_y_neg;
    logic y_is_major;
  } cmd_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/midpoint_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer
// Draws lines in all eight octants with an integer midpoint decision term.
//
//   Channel  Dir  tdata (low bit up)                          tuser        tlast
//   s_axis   in   x_start, y_start, x_end, y_end, colour_in   op           -
//   m_axis   out  pixel_x, pixel_y, pixel_colour              pixel_valid  last_pixel
//
// Every input word yields one output word. Sustained rate is one word per
// clock while the output is not back-pressured; a word is written into the
// queue, then the stepper's add/compare registers it into the output register.
// Up to four commands wait in the queue between front end and stepper. Reset
// clears the queue, the output valid flag and the active-line flag. Output
// back-pressure fills the queue and then lowers s_axis_tready_o.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDef
) (
  input  var logic clk_i,
  input  var logic rst_ni,
  input  var logic s_axis_tvalid_i,
  output var logic s_axis_tready_o,
  // x_start, y_start, x_end, y_end, colour_in, zero fill
  input  var logic [((4*COORD_BITS+mlr_pkg::ColourBits+7)/8)*8-1:0] s_axis_tdata_i,
  // op
  input  var logic s_axis_tuser_i,
  output var logic m_axis_tvalid_o,
  input  var logic m_axis_tready_i,
  // pixel_x, pixel_y, pixel_colour, zero fill
  output var logic [((2*COORD_BITS+mlr_pkg::ColourBits+7)/8)*8-1:0] m_axis_tdata_o,
  // pixel_valid
  output var logic m_axis_tuser_o,
  // last_pixel
  output var logic m_axis_tlast_o
);
  import mlr_pkg::*;

  localparam int unsigned InBits  = ((4*COORD_BITS + ColourBits + 7) / 8) * 8;
  localparam int unsigned OutBits = ((2*COORD_BITS + ColourBits + 7) / 8) * 8;
  localparam int unsigned QBits   = 5*COORD_BITS + ColourBits;

  cmd_ctrl_t             push_ctrl, pop_ctrl;
  logic                  push, pop, q_full, q_empty;
  logic [COORD_BITS-1:0] f_sx, f_sy, f_em, f_dmaj, f_dmin;
  logic [ColourBits-1:0] f_col;
  logic [QBits-1:0]      push_data, pop_data;

  mlr_front #(
    .COORD_BITS (COORD_BITS),
    .IN_BITS    (InBits)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .queue_full_i    (q_full),
    .push_o          (push),
    .ctrl_o          (push_ctrl),
    .start_x_o       (f_sx),
    .start_y_o       (f_sy),
    .end_major_o     (f_em),
    .delta_major_o   (f_dmaj),
    .delta_minor_o   (f_dmin),
    .colour_o        (f_col)
  );

  assign push_data = {f_col, f_dmin, f_dmaj, f_em, f_sy, f_sx};

  mlr_queue #(
    .DATA_BITS (QBits),
    .DEPTH     (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ctrl_i (push_ctrl),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_ctrl_o  (pop_ctrl),
    .pop_data_o  (pop_data)
  );

  mlr_back #(
    .COORD_BITS (COORD_BITS),
    .OUT_BITS   (OutBits)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .ctrl_i          (pop_ctrl),
    .start_x_i       (pop_data[COORD_BITS-1:0]),
    .start_y_i       (pop_data[2*COORD_BITS-1:COORD_BITS]),
    .end_major_i     (pop_data[3*COORD_BITS-1:2*COORD_BITS]),
    .delta_major_i   (pop_data[4*COORD_BITS-1:3*COORD_BITS]),
    .delta_minor_i   (pop_data[5*COORD_BITS-1:4*COORD_BITS]),
    .colour_i        (pop_data[QBits-1:5*COORD_BITS]),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTHESIS
  // The end-of-line flag only ever rides on a real pixel.
  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("last pixel flagged on an empty word");

  // A step with no line active returns an all-zero word.
  a_idle_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (m_axis_tdata_o == '0))
    else $error("empty word carries nonzero data");

  // A start word always produces a pixel through the queue and the output register when nothing stalls.
  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OpStart) && q_empty
      && !m_axis_tvalid_o ##1 m_axis_tready_i |=> m_axis_tvalid_o && m_axis_tuser_o)
    else $error("start word did not produce a pixel");
`endif

endmodule
`default_nettype wire

### hw/rtl/mlr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer front end
// Accepts input words, classifies start and step commands, and works out
// the octant, the major axis and the absolute deltas of a new line.
// ----------------------------------------------------------------------------
module mlr_front #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDef,
  parameter int unsigned IN_BITS    = 56
) (
  input  var logic                  s_axis_tvalid_i,
  output var logic                  s_axis_tready_o,
  input  var logic [IN_BITS-1:0]    s_axis_tdata_i,
  input  var logic                  s_axis_tuser_i,
  input  var logic                  queue_full_i,
  output var logic                  push_o,
  output var mlr_pkg::cmd_ctrl_t    ctrl_o,
  output var logic [COORD_BITS-1:0] start_x_o,
  output var logic [COORD_BITS-1:0] start_y_o,
  output var logic [COORD_BITS-1:0] end_major_o,
  output var logic [COORD_BITS-1:0] delta_major_o,
  output var logic [COORD_BITS-1:0] delta_minor_o,
  output var logic [mlr_pkg::ColourBits-1:0] colour_o
);
  import mlr_pkg::*;

  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  x_neg, y_neg, y_major;

  assign xs = s_axis_tdata_i[COORD_BITS-1:0];
  assign ys = s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
  assign xe = s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
  assign ye = s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS];

  always_comb begin
    x_neg   = xe < xs;
    y_neg   = ye < ys;
    dx      = x_neg ? (xs - xe) : (xe - xs);
    dy      = y_neg ? (ys - ye) : (ye - ys);
    y_major = dy > dx;
  end

  assign s_axis_tready_o = !queue_full_i;
  assign push_o          = s_axis_tvalid_i && !queue_full_i;

  assign ctrl_o.is_start   = (s_axis_tuser_i == OpStart);
  assign ctrl_o.dir_x_neg  = x_neg;
  assign ctrl_o.dir_y_neg  = y_neg;
  assign ctrl_o.y_is_major = y_major;

  assign start_x_o     = xs;
  assign start_y_o     = ys;
  assign end_major_o   = y_major ? ye : xe;
  assign delta_major_o = y_major ? dy : dx;
  assign delta_minor_o = y_major ? dx : dy;
  assign colour_o      = s_axis_tdata_i[4*COORD_BITS+ColourBits-1:4*COORD_BITS];

endmodule
`default_nettype wire

### hw/rtl/mlr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer command queue
// Small register FIFO that decouples the front end from the stepper.
// ----------------------------------------------------------------------------
module mlr_queue #(
  parameter int unsigned DATA_BITS = 64,
  parameter int unsigned DEPTH     = mlr_pkg::QueueDepth
) (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var logic                 push_i,
  input  var mlr_pkg::cmd_ctrl_t   push_ctrl_i,
  input  var logic [DATA_BITS-1:0] push_data_i,
  output var logic                 full_o,
  input  var logic                 pop_i,
  output var logic                 empty_o,
  output var mlr_pkg::cmd_ctrl_t   pop_ctrl_o,
  output var logic [DATA_BITS-1:0] pop_data_o
);
  import mlr_pkg::*;

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  cmd_ctrl_t            ctrl_mem [DEPTH];
  logic [DATA_BITS-1:0] data_mem [DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o   = (count_q == CntBits'(DEPTH));
  assign empty_o  = (count_q == '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;

  assign pop_ctrl_o = ctrl_mem[rd_ptr_q];
  assign pop_data_o = data_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ctrl_mem[wr_ptr_q] <= push_ctrl_i;
      data_mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mlr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Midpoint line rasterizer stepper
// Holds the line state, takes one command per cycle from the queue while the
// output is not stalled, and registers one pixel word per command on m_axis.
// ----------------------------------------------------------------------------
module mlr_back #(
  parameter int unsigned COORD_BITS = mlr_pkg::CoordBitsDef,
  parameter int unsigned OUT_BITS   = 32
) (
  input  var logic                  clk_i,
  input  var logic                  rst_ni,
  input  var logic                  empty_i,
  output var logic                  pop_o,
  input  var mlr_pkg::cmd_ctrl_t    ctrl_i,
  input  var logic [COORD_BITS-1:0] start_x_i,
  input  var logic [COORD_BITS-1:0] start_y_i,
  input  var logic [COORD_BITS-1:0] end_major_i,
  input  var logic [COORD_BITS-1:0] delta_major_i,
  input  var logic [COORD_BITS-1:0] delta_minor_i,
  input  var logic [mlr_pkg::ColourBits-1:0] colour_i,
  output var logic                  m_axis_tvalid_o,
  input  var logic                  m_axis_tready_i,
  output var logic [OUT_BITS-1:0]   m_axis_tdata_o,
  output var logic                  m_axis_tuser_o,
  output var logic                  m_axis_tlast_o
);
  import mlr_pkg::*;

  // Decision term is twice the midpoint error: it spans two deltas plus sign.
  localparam int unsigned DecBits = COORD_BITS + 3;
  localparam int unsigned PadBits = OUT_BITS - 2*COORD_BITS - ColourBits;

  logic [COORD_BITS-1:0]     cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0]     end_major_q, end_major_d;
  logic signed [DecBits-1:0] decision_q, decision_d;
  logic signed [DecBits-1:0] inc_pos_q, inc_pos_d, inc_neg_q, inc_neg_d;
  logic                      dir_x_neg_q, dir_x_neg_d, dir_y_neg_q, dir_y_neg_d;
  logic                      y_major_q, y_major_d;
  logic                      active_q, active_d;
  logic [ColourBits-1:0]     colour_q, colour_d;

  logic                      out_valid_q;
  logic [OUT_BITS-1:0]       out_data_q, out_data_d;
  logic                      out_user_q, out_user_d, out_last_q, out_last_d;

  logic signed [DecBits-1:0] dmin2, dmaj2, dmaj1;
  logic [COORD_BITS-1:0]     step_x, step_y, nx, ny, major_next;
  logic                      minor_step, last;

  assign pop_o = !empty_i && (!out_valid_q || m_axis_tready_i);

  assign dmin2 = signed'({2'b00, delta_minor_i, 1'b0});
  assign dmaj2 = signed'({2'b00, delta_major_i, 1'b0});
  assign dmaj1 = signed'({3'b000, delta_major_i});

  assign step_x = dir_x_neg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
  assign step_y = dir_y_neg_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    end_major_d = end_major_q;
    decision_d  = decision_q;
    inc_pos_d   = inc_pos_q;
    inc_neg_d   = inc_neg_q;
    dir_x_neg_d = dir_x_neg_q;
    dir_y_neg_d = dir_y_neg_q;
    y_major_d   = y_major_q;
    active_d    = active_q;
    colour_d    = colour_q;
    out_data_d  = '0;
    out_user_d  = 1'b0;
    out_last_d  = 1'b0;

    // The minor axis steps only on a strictly positive decision term.
    minor_step = !decision_q[DecBits-1] && (decision_q != '0);
    nx = (!y_major_q || minor_step) ? step_x : cur_x_q;
    ny = ( y_major_q || minor_step) ? step_y : cur_y_q;
    major_next = y_major_q ? ny : nx;
    last = 1'b0;

    if (ctrl_i.is_start) begin
      cur_x_d     = start_x_i;
      cur_y_d     = start_y_i;
      end_major_d = end_major_i;
      decision_d  = dmin2 - dmaj1;
      inc_pos_d   = dmin2 - dmaj2;
      inc_neg_d   = dmin2;
      dir_x_neg_d = ctrl_i.dir_x_neg;
      dir_y_neg_d = ctrl_i.dir_y_neg;
      y_major_d   = ctrl_i.y_is_major;
      colour_d    = colour_i;
      last        = (delta_major_i == '0);
      active_d    = !last;
      out_data_d  = {{PadBits{1'b0}}, colour_i, start_y_i, start_x_i};
      out_user_d  = 1'b1;
      out_last_d  = last;
    end else if (active_q) begin
      cur_x_d    = nx;
      cur_y_d    = ny;
      decision_d = decision_q + (minor_step ? inc_pos_q : inc_neg_q);
      last       = (major_next == end_major_q);
      active_d   = !last;
      out_data_d = {{PadBits{1'b0}}, colour_q, ny, nx};
      out_user_d = 1'b1;
      out_last_d = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= active_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      end_major_q <= end_major_d;
      decision_q  <= decision_d;
      inc_pos_q   <= inc_pos_d;
      inc_neg_q   <= inc_neg_d;
      dir_x_neg_q <= dir_x_neg_d;
      dir_y_neg_q <= dir_y_neg_d;
      y_major_q   <= y_major_d;
      colour_q    <= colour_d;
      out_data_q  <= out_data_d;
      out_user_q  <= out_user_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire
